// File: hdl/clamped_uniform_bspline_eval_assert.svh
// assertion macros used by the checker file cube_chk
`ifndef CLAMPED_UNIFORM_BSPLINE_EVAL_ASSERT_SVH
`define CLAMPED_UNIFORM_BSPLINE_EVAL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CUBE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cube assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CUBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cube assertion failed");

`endif

// File: hdl/cube_pkg.sv
// ----------------------------------------------------------------------------
// cube_pkg
// shared types and constants of the clamped uniform b-spline evaluator
// ----------------------------------------------------------------------------
package cube_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 64;
    localparam int MAX_DEGREE = 5;

    localparam int PT_AW  = 6;              // point store address
    localparam int U_W    = FRAC_BITS + 7;  // knot parameter u
    localparam int W_W    = FRAC_BITS + 1;  // basis weight, 1.0 included
    localparam int DEN_W  = U_W + 1;
    localparam int PROD_W = U_W + W_W;
    localparam int DIVN_W = 32 + FRAC_BITS; // divider dividend
    localparam int DS_W   = 32 + U_W + 1;   // shifted divisor
    localparam int QC_W   = 5;              // divider bit count
    localparam int ACC_W  = 32 + W_W + 3;
    localparam int IX_W   = 3;              // basis loop index

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TOTAL, ST_RANGE, ST_ERR, ST_END_RD, ST_END_OUT,
        ST_DIVU_GO, ST_DIVU_WAIT, ST_KSET, ST_LR, ST_MUL1, ST_DEN,
        ST_DIV1_WAIT, ST_MUL2, ST_DIV2_GO, ST_DIV2_WAIT, ST_SAVE, ST_CHK_R,
        ST_JEND, ST_ACC_INIT, ST_ACC_RD, ST_ACC_MUL, ST_ACC_ADD, ST_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_TOTAL, OP_END_RD, OP_END_OUT, OP_ERR_OUT,
        OP_DIVU, OP_KSET, OP_LR, OP_MUL1, OP_DZ, OP_DIV1, OP_MUL2, OP_DIV2,
        OP_SAVE, OP_JEND, OP_ACC_INIT, OP_ACC_RD, OP_ACC_MUL, OP_ACC_ADD,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        logic cfg_err;
        logic endpoint;
        logic div_busy;
        logic den_zero;
        logic r_eq_j;
        logic j_eq_p;
        logic r_eq_p;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/cube_div.sv
// ----------------------------------------------------------------------------
// cube_div
// restoring divider, one quotient bit per cycle, shared by all divisions
// ----------------------------------------------------------------------------
module cube_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          wide,
    input  logic [cube_pkg::DIVN_W-1:0]   dividend,
    input  logic [31:0]                   divisor,
    output logic                          busy,
    output logic [cube_pkg::U_W-1:0]      quotient
);

    logic                          busy_reg, busy_next;
    logic [cube_pkg::QC_W-1:0]     cnt_reg, cnt_next;
    logic [cube_pkg::DIVN_W-1:0]   rem_reg, rem_next;
    logic [cube_pkg::DS_W-1:0]     dsh_reg, dsh_next;
    logic [cube_pkg::U_W-1:0]      q_reg, q_next;
    logic                          fits;

    assign fits = {{(cube_pkg::DS_W-cube_pkg::DIVN_W){1'b0}}, rem_reg} >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = dividend;
            q_next    = '0;
            if (wide)
            begin
                cnt_next = cube_pkg::QC_W'(cube_pkg::U_W);
                dsh_next = cube_pkg::DS_W'(divisor) << (cube_pkg::U_W - 1);
            end
            else
            begin
                cnt_next = cube_pkg::QC_W'(cube_pkg::W_W);
                dsh_next = cube_pkg::DS_W'(divisor) << (cube_pkg::W_W - 1);
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg[cube_pkg::DIVN_W-1:0];
            end
            q_next   = {q_reg[cube_pkg::U_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cube_pkg::QC_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// File: hdl/cube_ctrl.sv
// ----------------------------------------------------------------------------
// cube_ctrl
// sequencer: steps the datapath through range check, division, basis and sum
// ----------------------------------------------------------------------------
module cube_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    action,
    input  cube_pkg::dp_status_t    status,
    output logic                    in_ready,
    output cube_pkg::dp_op_t        op
);

    cube_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cube_pkg::ST_IDLE:
                if (in_valid && action == cube_pkg::ACT_EVAL) state_next = cube_pkg::ST_TOTAL;
            cube_pkg::ST_TOTAL:
                state_next = status.cfg_err ? cube_pkg::ST_ERR : cube_pkg::ST_RANGE;
            cube_pkg::ST_RANGE:
                state_next = status.endpoint ? cube_pkg::ST_END_RD : cube_pkg::ST_DIVU_GO;
            cube_pkg::ST_ERR:
                if (status.out_free) state_next = cube_pkg::ST_IDLE;
            cube_pkg::ST_END_RD:
                state_next = cube_pkg::ST_END_OUT;
            cube_pkg::ST_END_OUT:
                if (status.out_free) state_next = cube_pkg::ST_IDLE;
            cube_pkg::ST_DIVU_GO:
                state_next = cube_pkg::ST_DIVU_WAIT;
            cube_pkg::ST_DIVU_WAIT:
                if (!status.div_busy) state_next = cube_pkg::ST_KSET;
            cube_pkg::ST_KSET:
                state_next = cube_pkg::ST_LR;
            cube_pkg::ST_LR:
                state_next = cube_pkg::ST_MUL1;
            cube_pkg::ST_MUL1:
                state_next = cube_pkg::ST_DEN;
            cube_pkg::ST_DEN:
                state_next = status.den_zero ? cube_pkg::ST_CHK_R : cube_pkg::ST_DIV1_WAIT;
            cube_pkg::ST_DIV1_WAIT:
                if (!status.div_busy) state_next = cube_pkg::ST_MUL2;
            cube_pkg::ST_MUL2:
                state_next = cube_pkg::ST_DIV2_GO;
            cube_pkg::ST_DIV2_GO:
                state_next = cube_pkg::ST_DIV2_WAIT;
            cube_pkg::ST_DIV2_WAIT:
                if (!status.div_busy) state_next = cube_pkg::ST_SAVE;
            cube_pkg::ST_SAVE:
                state_next = cube_pkg::ST_CHK_R;
            cube_pkg::ST_CHK_R:
                state_next = status.r_eq_j ? cube_pkg::ST_JEND : cube_pkg::ST_MUL1;
            cube_pkg::ST_JEND:
                state_next = status.j_eq_p ? cube_pkg::ST_ACC_INIT : cube_pkg::ST_LR;
            cube_pkg::ST_ACC_INIT:
                state_next = cube_pkg::ST_ACC_RD;
            cube_pkg::ST_ACC_RD:
                state_next = cube_pkg::ST_ACC_MUL;
            cube_pkg::ST_ACC_MUL:
                state_next = cube_pkg::ST_ACC_ADD;
            cube_pkg::ST_ACC_ADD:
                state_next = status.r_eq_p ? cube_pkg::ST_FIN : cube_pkg::ST_ACC_RD;
            cube_pkg::ST_FIN:
                if (status.out_free) state_next = cube_pkg::ST_IDLE;
            default:
                state_next = cube_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = cube_pkg::OP_NOP;
        unique case (state_reg)
            cube_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) op = cube_pkg::OP_ACCEPT;
            end
            cube_pkg::ST_TOTAL:     op = cube_pkg::OP_TOTAL;
            cube_pkg::ST_ERR:       if (status.out_free) op = cube_pkg::OP_ERR_OUT;
            cube_pkg::ST_END_RD:    op = cube_pkg::OP_END_RD;
            cube_pkg::ST_END_OUT:   if (status.out_free) op = cube_pkg::OP_END_OUT;
            cube_pkg::ST_DIVU_GO:   op = cube_pkg::OP_DIVU;
            cube_pkg::ST_KSET:      op = cube_pkg::OP_KSET;
            cube_pkg::ST_LR:        op = cube_pkg::OP_LR;
            cube_pkg::ST_MUL1:      op = cube_pkg::OP_MUL1;
            cube_pkg::ST_DEN:       op = status.den_zero ? cube_pkg::OP_DZ : cube_pkg::OP_DIV1;
            cube_pkg::ST_MUL2:      op = cube_pkg::OP_MUL2;
            cube_pkg::ST_DIV2_GO:   op = cube_pkg::OP_DIV2;
            cube_pkg::ST_SAVE:      op = cube_pkg::OP_SAVE;
            cube_pkg::ST_JEND:      op = cube_pkg::OP_JEND;
            cube_pkg::ST_ACC_INIT:  op = cube_pkg::OP_ACC_INIT;
            cube_pkg::ST_ACC_RD:    op = cube_pkg::OP_ACC_RD;
            cube_pkg::ST_ACC_MUL:   op = cube_pkg::OP_ACC_MUL;
            cube_pkg::ST_ACC_ADD:   op = cube_pkg::OP_ACC_ADD;
            cube_pkg::ST_FIN:       if (status.out_free) op = cube_pkg::OP_FIN;
            default:                op = cube_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cube_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/cube_dp.sv
// ----------------------------------------------------------------------------
// cube_dp
// datapath: config registers, point store, basis registers, sum and output
// ----------------------------------------------------------------------------
module cube_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cube_pkg::dp_op_t                   op,
    output cube_pkg::dp_status_t               status,
    input  logic                               cfg_we,
    input  logic [cube_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               action,
    input  logic [5:0]                         point_index,
    input  logic signed [31:0]                 in_x,
    input  logic signed [31:0]                 in_y,
    input  logic signed [31:0]                 in_z,
    input  logic signed [31:0]                 time_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 out_x,
    output logic signed [31:0]                 out_y,
    output logic signed [31:0]                 out_z,
    output logic                               config_error
);

    localparam int F  = cube_pkg::FRAC_BITS;
    localparam int UW = cube_pkg::U_W;
    localparam int WW = cube_pkg::W_W;
    localparam int XW = cube_pkg::IX_W;
    localparam int AW = cube_pkg::PT_AW;
    localparam int MD = cube_pkg::MAX_DEGREE;

    // knot value of the clamped uniform knot vector, integer part
    function automatic logic [6:0] knot_at(input logic [7:0] i, input logic [2:0] p,
                                           input logic [6:0] n);
        logic [6:0] kv;
        if (i <= 8'(p))
            kv = '0;
        else if (i >= 8'(n))
            kv = n - 7'(p);
        else
            kv = 7'(i - 8'(p));
        return kv;
    endfunction

    // round to nearest, ties up, then saturate to 32 bits
    function automatic logic signed [31:0] finish(input logic signed [cube_pkg::ACC_W-1:0] s);
        logic signed [cube_pkg::ACC_W:0] sr;
        logic signed [cube_pkg::ACC_W-F:0] q;
        logic signed [31:0] res;
        sr = (cube_pkg::ACC_W+1)'(s) + (cube_pkg::ACC_W+1)'(1 << (F - 1));
        q  = (cube_pkg::ACC_W-F+1)'(sr >>> F);
        if (q > (cube_pkg::ACC_W-F+1)'(32'sh7fffffff))
            res = 32'sh7fffffff;
        else if (q < -(cube_pkg::ACC_W-F+1)'(33'sh080000000))
            res = 32'sh80000000;
        else
            res = q[31:0];
        return res;
    endfunction

    // configuration
    logic [2:0]  deg_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] ivl_reg;

    // per-item working registers
    logic [2:0]          p_reg;
    logic [6:0]          n_reg;
    logic [31:0]         iv_reg;
    logic signed [31:0]  t_reg;
    logic [38:0]         total_reg;
    logic [UW-1:0]       u_reg;
    logic [AW-1:0]       k_reg;
    logic [XW-1:0]       j_reg, r_reg;
    logic [WW-1:0]       nb_reg [0:MD];
    logic [UW-1:0]       left_reg [0:MD];
    logic [UW-1:0]       right_reg [0:MD];
    logic [WW-1:0]       saved_reg, cur_reg;
    logic [cube_pkg::DEN_W-1:0]  den_reg;
    logic [cube_pkg::PROD_W-1:0] prod_reg;
    logic signed [WW+32:0]       px_reg, py_reg, pz_reg;
    logic signed [cube_pkg::ACC_W-1:0] sx_reg, sy_reg, sz_reg;
    logic                out_valid_reg;
    logic signed [31:0]  ox_reg, oy_reg, oz_reg;
    logic                oerr_reg;

    // point store
    logic signed [31:0]  mem_x [0:cube_pkg::MAX_POINTS-1];
    logic signed [31:0]  mem_y [0:cube_pkg::MAX_POINTS-1];
    logic signed [31:0]  mem_z [0:cube_pkg::MAX_POINTS-1];
    logic signed [31:0]  rd_x_reg, rd_y_reg, rd_z_reg;
    logic [AW-1:0]       rd_addr;
    logic                rd_en, wr_en;

    // divider
    logic                div_start, div_wide, div_busy;
    logic [cube_pkg::DIVN_W-1:0] div_num;
    logic [31:0]         div_den;
    logic [UW-1:0]       div_q;

    logic [2:0]  p_clamp;
    logic [6:0]  n_clamp;
    logic [31:0] iv_clamp;
    logic [XW-1:0] r_inc, j_m_r;
    logic [7:0]  k_raw;
    logic [6:0]  n_m1;
    logic [UW-1:0] kl, kr;
    logic [6:0]  spans;

    assign p_clamp  = (deg_reg == 3'd0) ? 3'd1 :
                      (deg_reg > 3'(MD)) ? 3'(MD) : deg_reg;
    assign n_clamp  = (cnt_reg > 7'(cube_pkg::MAX_POINTS)) ? 7'(cube_pkg::MAX_POINTS) : cnt_reg;
    assign iv_clamp = (ivl_reg == 32'd0) ? 32'd1 : ivl_reg;
    assign r_inc    = r_reg + 1'b1;
    assign j_m_r    = j_reg - r_reg;
    assign n_m1     = n_reg - 7'd1;
    assign spans    = n_reg - 7'(p_reg);
    assign k_raw    = 8'(p_reg) + 8'(div_q >> F);
    assign kl       = {knot_at(8'(k_reg) + 8'd1 - 8'(j_reg), p_reg, n_reg), {F{1'b0}}};
    assign kr       = {knot_at(8'(k_reg) + 8'(j_reg), p_reg, n_reg), {F{1'b0}}};

    assign div_start = (op == cube_pkg::OP_DIVU) || (op == cube_pkg::OP_DIV1) ||
                       (op == cube_pkg::OP_DIV2);
    assign div_wide  = (op == cube_pkg::OP_DIVU);
    assign div_num   = div_wide ? {t_reg, {F{1'b0}}} : cube_pkg::DIVN_W'(prod_reg);
    assign div_den   = div_wide ? iv_reg : 32'(den_reg);

    cube_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .wide     (div_wide),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        status.cfg_err  = (7'(p_reg) + 7'd1) > n_reg;
        status.endpoint = t_reg[31] || (t_reg == 32'sd0) ||
                          ({7'd0, t_reg[31:0]} >= total_reg);
        status.div_busy = div_busy;
        status.den_zero = (den_reg == '0);
        status.r_eq_j   = (r_reg == j_reg);
        status.j_eq_p   = (j_reg == XW'(p_reg));
        status.r_eq_p   = (r_reg == XW'(p_reg));
        status.out_free = !out_valid_reg || out_ready;
    end

    // memory port selection
    always_comb
    begin
        wr_en   = (op == cube_pkg::OP_ACCEPT) && (action == cube_pkg::ACT_LOAD) &&
                  ({1'b0, point_index} < 7'(cube_pkg::MAX_POINTS));
        rd_en   = (op == cube_pkg::OP_END_RD) || (op == cube_pkg::OP_ACC_RD);
        if (op == cube_pkg::OP_END_RD)
            rd_addr = (t_reg[31] || t_reg == 32'sd0) ? '0 : AW'(n_m1);
        else
            rd_addr = AW'(7'(k_reg) - 7'(p_reg) + 7'(r_reg));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[AW'(point_index)] <= in_x;
            mem_y[AW'(point_index)] <= in_y;
            mem_z[AW'(point_index)] <= in_z;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg       <= 3'd3;
            cnt_reg       <= 7'd4;
            ivl_reg       <= 32'd65536;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cube_pkg::CFG_DEGREE:   deg_reg <= cfg_data[2:0];
                    cube_pkg::CFG_COUNT:    cnt_reg <= cfg_data[6:0];
                    cube_pkg::CFG_INTERVAL: ivl_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (op == cube_pkg::OP_END_OUT || op == cube_pkg::OP_ERR_OUT ||
                op == cube_pkg::OP_FIN)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            cube_pkg::OP_ACCEPT:
            begin
                p_reg  <= p_clamp;
                n_reg  <= n_clamp;
                iv_reg <= iv_clamp;
                t_reg  <= time_value;
            end
            cube_pkg::OP_TOTAL:
                total_reg <= 39'(spans) * 39'(iv_reg);
            cube_pkg::OP_ERR_OUT:
            begin
                ox_reg   <= '0;
                oy_reg   <= '0;
                oz_reg   <= '0;
                oerr_reg <= 1'b1;
            end
            cube_pkg::OP_END_OUT:
            begin
                ox_reg   <= rd_x_reg;
                oy_reg   <= rd_y_reg;
                oz_reg   <= rd_z_reg;
                oerr_reg <= 1'b0;
            end
            cube_pkg::OP_KSET:
            begin
                u_reg <= div_q;
                k_reg <= (k_raw > 8'(n_m1)) ? AW'(n_m1) : AW'(k_raw);
                for (int i = 0; i <= MD; i++)
                    nb_reg[i] <= (i == 0) ? WW'(1 << F) : '0;
                j_reg <= XW'(1);
            end
            cube_pkg::OP_LR:
            begin
                left_reg[j_reg]  <= (u_reg > kl) ? u_reg - kl : '0;
                right_reg[j_reg] <= (kr > u_reg) ? kr - u_reg : '0;
                r_reg     <= '0;
                saved_reg <= '0;
            end
            cube_pkg::OP_MUL1:
            begin
                den_reg  <= cube_pkg::DEN_W'(right_reg[r_inc]) +
                            cube_pkg::DEN_W'(left_reg[j_m_r]);
                cur_reg  <= nb_reg[r_reg];
                prod_reg <= cube_pkg::PROD_W'(right_reg[r_inc]) *
                            cube_pkg::PROD_W'(nb_reg[r_reg]);
            end
            cube_pkg::OP_DZ:
            begin
                nb_reg[r_reg] <= saved_reg;
                saved_reg     <= '0;
                r_reg         <= r_inc;
            end
            cube_pkg::OP_MUL2:
            begin
                nb_reg[r_reg] <= saved_reg + div_q[WW-1:0];
                prod_reg      <= cube_pkg::PROD_W'(left_reg[j_m_r]) *
                                 cube_pkg::PROD_W'(cur_reg);
            end
            cube_pkg::OP_SAVE:
            begin
                saved_reg <= div_q[WW-1:0];
                r_reg     <= r_inc;
            end
            cube_pkg::OP_JEND:
            begin
                nb_reg[j_reg] <= saved_reg;
                j_reg         <= j_reg + 1'b1;
            end
            cube_pkg::OP_ACC_INIT:
            begin
                r_reg  <= '0;
                sx_reg <= '0;
                sy_reg <= '0;
                sz_reg <= '0;
            end
            cube_pkg::OP_ACC_MUL:
            begin
                px_reg <= $signed({1'b0, nb_reg[r_reg]}) * rd_x_reg;
                py_reg <= $signed({1'b0, nb_reg[r_reg]}) * rd_y_reg;
                pz_reg <= $signed({1'b0, nb_reg[r_reg]}) * rd_z_reg;
            end
            cube_pkg::OP_ACC_ADD:
            begin
                sx_reg <= sx_reg + cube_pkg::ACC_W'(px_reg);
                sy_reg <= sy_reg + cube_pkg::ACC_W'(py_reg);
                sz_reg <= sz_reg + cube_pkg::ACC_W'(pz_reg);
                r_reg  <= r_inc;
            end
            cube_pkg::OP_FIN:
            begin
                ox_reg   <= finish(sx_reg);
                oy_reg   <= finish(sy_reg);
                oz_reg   <= finish(sz_reg);
                oerr_reg <= 1'b0;
            end
            default:
                ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign config_error = oerr_reg;

endmodule

// File: hdl/clamped_uniform_bspline_eval.sv
// ----------------------------------------------------------------------------
// clamped_uniform_bspline_eval
// 3d clamped uniform b-spline evaluator, signed q16.16, cox-de boor basis
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes one word per item: action 0 writes
// in_x/in_y/in_z into store slot point_index, action 1 evaluates at time_value.
// output channel (out_valid/out_ready) gives one word per evaluate, none per
// load. config port (cfg_we/cfg_index/cfg_data) sets degree, point count and
// segment interval; write it only while idle.
// a load is written while the block stays idle. an evaluate that hits an end
// point or finds the point count too small skips the division; otherwise it
// runs the range check and u division, then the basis terms (p*(p+1)/2 of
// them, each with two divisions unless the denominator is zero), a step per
// degree and a sum over the p+1 points. all divisions use the shared
// restoring divider, one quotient bit per cycle.
// one item is worked on at a time; in_ready is high only between items.
// a finished result sits in the output register; if out_ready is low the
// next load is still taken, and the next evaluate waits before its result.
// reset restores degree 3, count 4, interval 1.0 and empties the output;
// the point store holds nothing valid until written.
// ----------------------------------------------------------------------------
module clamped_uniform_bspline_eval
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cube_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [5:0]                         point_index,
    input  logic signed [31:0]                 in_x,
    input  logic signed [31:0]                 in_y,
    input  logic signed [31:0]                 in_z,
    input  logic signed [31:0]                 time_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 out_x,
    output logic signed [31:0]                 out_y,
    output logic signed [31:0]                 out_z,
    output logic                               config_error
);

    cube_pkg::dp_op_t     op;
    cube_pkg::dp_status_t status;

    cube_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    cube_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .point_index  (point_index),
        .in_x         (in_x),
        .in_y         (in_y),
        .in_z         (in_z),
        .time_value   (time_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .config_error (config_error)
    );

endmodule

// File: hdl/cube_chk.sv
// ----------------------------------------------------------------------------
// cube_chk
// port-level checks of the evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "clamped_uniform_bspline_eval_assert.svh"

module cube_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                action,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  out_x,
    input logic signed [31:0]  out_y,
    input logic signed [31:0]  out_z,
    input logic                config_error
);

    // a stalled result word holds
    `CUBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(config_error))

    // a load never blocks the next word
    `CUBE_ASSERT_NEXT(a_load_ready, in_valid && in_ready && action == 1'b0, in_ready)

    // an evaluate keeps the input closed while it runs
    `CUBE_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && action == 1'b1, !in_ready)

    // error results carry a zero point
    `CUBE_ASSERT_IMPLY(a_err_zero, out_valid && config_error, out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0)

endmodule

bind clamped_uniform_bspline_eval cube_chk u_cube_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .config_error (config_error)
);
